// ----- sv/roman_numeral_encoder_assert.svh -----
// Assertion macros for the roman numeral encoder RTL (used by the back end).
`ifndef ROMAN_NUMERAL_ENCODER_ASSERT_SVH
`define ROMAN_NUMERAL_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check that prop holds at every clock edge outside reset.
`define RNE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that cond never holds outside reset.
`define RNE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define RNE_ASSERT(lbl, clk, rst_n, prop, msg)
`define RNE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- sv/rne_pkg.sv -----
`default_nettype none

package rne_pkg;

  localparam int unsigned VALUE_W  = 14;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned LETTER_W = 7;
  localparam int unsigned NUM_POS  = 4;
  localparam int unsigned POS_W    = 2;
  localparam int unsigned DIGIT_W  = 4;

  localparam int unsigned QUEUE_DEPTH = 2;

  // One item's decimal digits, lowest position first, with a flag per
  // position that says whether the digit produces letters.
  typedef struct packed {
    logic [NUM_POS-1:0][DIGIT_W-1:0] digits;
    logic [NUM_POS-1:0]              en;
  } rne_entry_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_REM,
    FS_PUSH
  } front_state_e;

endpackage

`default_nettype wire

// ----- sv/rne_if.sv -----
`default_nettype none

interface rne_in_if;
  logic                               valid;
  logic                               ready;
  logic [rne_pkg::VALUE_W-1:0]        value;
  logic [rne_pkg::COUNT_W-1:0]        digit_count;

  modport source (output valid, output value, output digit_count, input ready);
  modport sink (input valid, input value, input digit_count, output ready);
endinterface

interface rne_out_if;
  logic                               valid;
  logic                               ready;
  logic [rne_pkg::LETTER_W-1:0]       letter;
  logic                               last;

  modport source (output valid, output letter, output last, input ready);
  modport sink (input valid, input letter, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/rne_front.sv -----
`default_nettype none

module rne_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  rne_in_if.sink              in_i,
  output logic                push_o,
  output rne_pkg::rne_entry_t entry_o,
  input  wire                 full_i
);

  localparam int unsigned VW   = rne_pkg::VALUE_W;
  localparam int unsigned PW   = rne_pkg::POS_W;
  localparam int unsigned PRDW = 30;

  rne_pkg::front_state_e state_q, state_d;

  logic [VW-1:0]       v_q, v_d;
  logic [VW-1:0]       q_q, q_d;
  logic [PW-1:0]       pos_q, pos_d;
  rne_pkg::rne_entry_t entry_q, entry_d;

  logic                accept;
  logic [2:0]          n_sat;
  logic [PRDW-1:0]     prod;
  logic [VW-1:0]       rem;
  logic                digit_ok;

  // Reciprocal of the position's power of ten, exact for every 14-bit value.
  function automatic logic [15:0] recip_mul(input logic [PW-1:0] pos);
    logic [15:0] m;
    unique case (pos)
      2'd0:    m = 16'd1;
      2'd1:    m = 16'd52429;
      2'd2:    m = 16'd5243;
      default: m = 16'd16778;
    endcase
    return m;
  endfunction

  function automatic logic [4:0] recip_shift(input logic [PW-1:0] pos);
    logic [4:0] s;
    unique case (pos)
      2'd0:    s = 5'd0;
      2'd1:    s = 5'd19;
      2'd2:    s = 5'd19;
      default: s = 5'd24;
    endcase
    return s;
  endfunction

  function automatic logic [9:0] pow_ten(input logic [PW-1:0] pos);
    logic [9:0] p;
    unique case (pos)
      2'd0:    p = 10'd1;
      2'd1:    p = 10'd10;
      2'd2:    p = 10'd100;
      default: p = 10'd1000;
    endcase
    return p;
  endfunction

  assign accept = in_i.valid && in_i.ready;
  assign n_sat  = (in_i.digit_count > 3'd4) ? 3'd4 : in_i.digit_count;

  assign prod = PRDW'(v_q) * PRDW'(recip_mul(pos_q));
  assign rem  = v_q - VW'(24'(q_q) * 24'(pow_ten(pos_q)));

  // Thousands only spell 1 to 3; an oversized leading quotient spells nothing.
  assign digit_ok = (q_q != '0) && (q_q <= VW'(9)) &&
                    !((pos_q == PW'(3)) && (q_q > VW'(3)));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rne_pkg::FS_IDLE: begin
        if (accept && (n_sat != 3'd0)) begin
          state_d = rne_pkg::FS_DIV;
        end
      end
      rne_pkg::FS_DIV: begin
        state_d = rne_pkg::FS_REM;
      end
      rne_pkg::FS_REM: begin
        state_d = (pos_q == '0) ? rne_pkg::FS_PUSH : rne_pkg::FS_DIV;
      end
      rne_pkg::FS_PUSH: begin
        if ((entry_q.en == '0) || !full_i) begin
          state_d = rne_pkg::FS_IDLE;
        end
      end
      default: state_d = rne_pkg::FS_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    in_i.ready = 1'b0;
    push_o     = 1'b0;
    v_d        = v_q;
    q_d        = q_q;
    pos_d      = pos_q;
    entry_d    = entry_q;
    unique case (state_q)
      rne_pkg::FS_IDLE: begin
        in_i.ready = 1'b1;
        if (accept) begin
          v_d        = in_i.value;
          pos_d      = PW'(n_sat - 3'd1);
          entry_d.en = '0;
        end
      end
      rne_pkg::FS_DIV: begin
        q_d = VW'(prod >> recip_shift(pos_q));
      end
      rne_pkg::FS_REM: begin
        v_d                   = rem;
        entry_d.digits[pos_q] = q_q[rne_pkg::DIGIT_W-1:0];
        entry_d.en[pos_q]     = digit_ok;
        if (pos_q != '0) begin
          pos_d = pos_q - PW'(1);
        end
      end
      rne_pkg::FS_PUSH: begin
        // Drop items that spell no letters.
        push_o = (entry_q.en != '0) && !full_i;
      end
      default: ;
    endcase
  end

  assign entry_o = entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rne_pkg::FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    q_q     <= q_d;
    pos_q   <= pos_d;
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

// ----- sv/rne_fifo.sv -----
`default_nettype none

module rne_fifo #(
  parameter int unsigned Depth = rne_pkg::QUEUE_DEPTH
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  rne_pkg::rne_entry_t data_i,
  output logic                full_o,
  input  wire                 pop_i,
  output rne_pkg::rne_entry_t data_o,
  output logic                valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  rne_pkg::rne_entry_t mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/rne_back.sv -----
`default_nettype none

`include "roman_numeral_encoder_assert.svh"

module rne_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  input  rne_pkg::rne_entry_t entry_i,
  output logic                pop_o,
  rne_out_if.source           out_o
);

  localparam int unsigned PW = rne_pkg::POS_W;
  localparam int unsigned DW = rne_pkg::DIGIT_W;
  localparam int unsigned LW = rne_pkg::LETTER_W;
  localparam int unsigned NP = rne_pkg::NUM_POS;

  // Letter roles within a position
  localparam logic [1:0] SEL_UNIT = 2'd0;
  localparam logic [1:0] SEL_FIVE = 2'd1;
  localparam logic [1:0] SEL_TEN  = 2'd2;

  localparam logic [LW-1:0] CH_I = 7'd73;
  localparam logic [LW-1:0] CH_V = 7'd86;
  localparam logic [LW-1:0] CH_X = 7'd88;
  localparam logic [LW-1:0] CH_L = 7'd76;
  localparam logic [LW-1:0] CH_C = 7'd67;
  localparam logic [LW-1:0] CH_D = 7'd68;
  localparam logic [LW-1:0] CH_M = 7'd77;

  logic                     busy_q;
  logic [NP-1:0][DW-1:0]    digits_q;
  logic [NP-1:0]            en_q;
  logic [PW-1:0]            pos_q;
  logic [1:0]               step_q;
  logic                     out_valid_q;
  logic [LW-1:0]            letter_q;
  logic                     last_q;

  logic [DW-1:0]            cur_digit;
  logic [2:0]               cur_len;
  logic [1:0]               cur_sel;
  logic [NP-1:0]            lower_en;
  logic                     step_end;
  logic                     cur_last;
  logic                     out_free;
  logic                     emit;

  function automatic logic [2:0] shape_len(input logic [DW-1:0] d);
    logic [2:0] n;
    unique case (d)
      4'd1, 4'd5:       n = 3'd1;
      4'd2, 4'd4, 4'd6,
      4'd9:             n = 3'd2;
      4'd3, 4'd7:       n = 3'd3;
      4'd8:             n = 3'd4;
      default:          n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] shape_sel(input logic [DW-1:0] d, input logic [1:0] idx);
    logic [1:0] s;
    unique case (d)
      4'd4:             s = (idx == 2'd0) ? SEL_UNIT : SEL_FIVE;
      4'd5:             s = SEL_FIVE;
      4'd6, 4'd7, 4'd8: s = (idx == 2'd0) ? SEL_FIVE : SEL_UNIT;
      4'd9:             s = (idx == 2'd0) ? SEL_UNIT : SEL_TEN;
      default:          s = SEL_UNIT;
    endcase
    return s;
  endfunction

  function automatic logic [LW-1:0] pos_letter(input logic [PW-1:0] pos, input logic [1:0] sel);
    logic [LW-1:0] c;
    unique case (pos)
      2'd0:    c = (sel == SEL_UNIT) ? CH_I : ((sel == SEL_FIVE) ? CH_V : CH_X);
      2'd1:    c = (sel == SEL_UNIT) ? CH_X : ((sel == SEL_FIVE) ? CH_L : CH_C);
      2'd2:    c = (sel == SEL_UNIT) ? CH_C : ((sel == SEL_FIVE) ? CH_D : CH_M);
      default: c = CH_M;
    endcase
    return c;
  endfunction

  function automatic logic [PW-1:0] top_pos(input logic [NP-1:0] en);
    logic [PW-1:0] p;
    priority if (en[3]) p = 2'd3;
    else if (en[2])     p = 2'd2;
    else if (en[1])     p = 2'd1;
    else                p = 2'd0;
    return p;
  endfunction

  function automatic logic [NP-1:0] below_mask(input logic [PW-1:0] pos);
    logic [NP-1:0] m;
    unique case (pos)
      2'd0:    m = 4'b0000;
      2'd1:    m = 4'b0001;
      2'd2:    m = 4'b0011;
      default: m = 4'b0111;
    endcase
    return m;
  endfunction

  assign cur_digit = digits_q[pos_q];
  assign cur_len   = shape_len(cur_digit);
  assign cur_sel   = shape_sel(cur_digit, step_q);
  assign lower_en  = en_q & below_mask(pos_q);
  assign step_end  = (3'(step_q) == cur_len - 3'd1);
  assign cur_last  = step_end && (lower_en == '0);
  assign out_free  = !out_valid_q || out_o.ready;
  assign emit      = busy_q && out_free;
  assign pop_o     = !busy_q && valid_i;

  assign out_o.valid  = out_valid_q;
  assign out_o.letter = letter_q;
  assign out_o.last   = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
      end else if (emit && cur_last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      letter_q <= pos_letter(pos_q, cur_sel);
      last_q   <= cur_last;
      if (!step_end) begin
        step_q <= step_q + 2'd1;
      end else begin
        // Skip positions whose digit spells nothing.
        step_q <= 2'd0;
        pos_q  <= top_pos(lower_en);
      end
    end else if (pop_o) begin
      digits_q <= entry_i.digits;
      en_q     <= entry_i.en;
      pos_q    <= top_pos(entry_i.en);
      step_q   <= 2'd0;
    end
  end

  `RNE_ASSERT(a_pos_enabled, clk_i, rst_ni, busy_q |-> en_q[pos_q], "current position spells nothing")
  `RNE_ASSERT(a_step_in_shape, clk_i, rst_ni, busy_q |-> (cur_len > 3'(step_q)), "step past digit")
  `RNE_ASSERT(a_last_ends_item, clk_i, rst_ni, (emit && cur_last) |=> !busy_q, "busy after last")
  `RNE_ASSERT_NEVER(a_no_pop_busy, clk_i, rst_ni, pop_o && busy_q, "queue popped while busy")

endmodule

`default_nettype wire

// ----- sv/roman_numeral_encoder.sv -----
// Channel  Dir  Fields                      Transfer
// in_i     in   value[13:0], digit_count[2:0]  valid && ready
// out_o    out  letter[6:0], last              valid && ready
//
// The front takes an item, then visits a reciprocal-multiply state and a
// remainder state for each decimal position, and a push state to queue it.
// The back loads an item from the queue, then sends one letter per cycle
// while the output is not stalled, and loads the next item after the last letter.
// Reset clears control state only; no clearing pass is needed.
// A stalled output holds the back; a full queue holds the front.
`default_nettype none

module roman_numeral_encoder #(
  parameter int unsigned QueueDepth = rne_pkg::QUEUE_DEPTH
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  rne_in_if.sink    in_i,
  rne_out_if.source out_o
);

  logic                push;
  logic                full;
  logic                pop;
  logic                q_valid;
  rne_pkg::rne_entry_t push_entry;
  rne_pkg::rne_entry_t pop_entry;

  rne_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .push_o  (push),
    .entry_o (push_entry),
    .full_i  (full)
  );

  rne_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_entry),
    .valid_o (q_valid)
  );

  rne_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (pop_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ----- verif/rne_numeral_checker.sv -----
`default_nettype none

module rne_numeral_checker (
  input  wire       clk_i,
  input  wire       rst_ni,
  rne_in_if         in_mon,
  rne_out_if        out_mon,
  output int        fail_count,
  output int        pending
);

  localparam logic [rne_pkg::LETTER_W-1:0] CH_I = 7'h49;
  localparam logic [rne_pkg::LETTER_W-1:0] CH_V = 7'h56;
  localparam logic [rne_pkg::LETTER_W-1:0] CH_X = 7'h58;
  localparam logic [rne_pkg::LETTER_W-1:0] CH_L = 7'h4C;
  localparam logic [rne_pkg::LETTER_W-1:0] CH_C = 7'h43;
  localparam logic [rne_pkg::LETTER_W-1:0] CH_D = 7'h44;
  localparam logic [rne_pkg::LETTER_W-1:0] CH_M = 7'h4D;

  typedef enum int unsigned {
    SEL_UNIT,
    SEL_FIVE,
    SEL_TEN
  } numeral_sel_e;

  typedef struct packed {
    logic [rne_pkg::LETTER_W-1:0] letter;
    logic                         last;
  } numeral_t;

  numeral_t expected_letters[$];
  int       errors = 0;

  function automatic logic [rne_pkg::LETTER_W-1:0] numeral(int unsigned pos,
                                                           numeral_sel_e sel);
    case (pos)
      0: begin
        case (sel)
          SEL_UNIT: return CH_I;
          SEL_FIVE: return CH_V;
          default:  return CH_X;
        endcase
      end
      1: begin
        case (sel)
          SEL_UNIT: return CH_X;
          SEL_FIVE: return CH_L;
          default:  return CH_C;
        endcase
      end
      2: begin
        case (sel)
          SEL_UNIT: return CH_C;
          SEL_FIVE: return CH_D;
          default:  return CH_M;
        endcase
      end
      default: return CH_M;
    endcase
  endfunction

  function automatic void push_numeral(int unsigned pos, numeral_sel_e sel);
    numeral_t n;
    n.letter = numeral(pos, sel);
    n.last   = 1'b0;
    expected_letters.push_back(n);
  endfunction

  // Subtractive form of one decimal digit at the given position.
  function automatic void encode_digit(int unsigned pos, int unsigned digit);
    case (digit)
      1, 2, 3: begin
        repeat (digit) push_numeral(pos, SEL_UNIT);
      end
      4: begin
        push_numeral(pos, SEL_UNIT);
        push_numeral(pos, SEL_FIVE);
      end
      5: push_numeral(pos, SEL_FIVE);
      6, 7, 8: begin
        push_numeral(pos, SEL_FIVE);
        repeat (digit - 5) push_numeral(pos, SEL_UNIT);
      end
      9: begin
        push_numeral(pos, SEL_UNIT);
        push_numeral(pos, SEL_TEN);
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_numerals(logic [rne_pkg::VALUE_W-1:0] value,
                                           logic [rne_pkg::COUNT_W-1:0] digit_count);
    int unsigned rest;
    int unsigned positions;
    int unsigned scale;
    int unsigned digit;
    int          first;
    first     = expected_letters.size();
    rest      = 32'(value);
    positions = 32'(digit_count);
    if (positions > rne_pkg::NUM_POS) begin
      positions = rne_pkg::NUM_POS;
    end
    for (int k = positions; k > 0; k--) begin
      scale = 10 ** (k - 1);
      digit = rest / scale;
      rest  = rest % scale;
      // drop zero, oversized leading digits and thousands above three
      if (digit >= 1 && digit <= 9 && !(k == 4 && digit > 3)) begin
        encode_digit(k - 1, digit);
      end
    end
    if (expected_letters.size() > first) begin
      expected_letters[expected_letters.size() - 1].last = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin
    numeral_t exp_n;
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready) begin
        predict_numerals(in_mon.value, in_mon.digit_count);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_letters.size() == 0) begin
          $display("%0t: unexpected transfer: expected none, actual letter %c last %0d",
                   $time, out_mon.letter, out_mon.last);
          errors++;
        end else begin
          exp_n = expected_letters.pop_front();
          if (out_mon.letter !== exp_n.letter) begin
            $display("%0t: letter mismatch: expected %c (%0d), actual %c (%0d)", $time,
                     exp_n.letter, exp_n.letter, out_mon.letter, out_mon.letter);
            errors++;
          end
          if (out_mon.last !== exp_n.last) begin
            $display("%0t: last mismatch: expected %0d, actual %0d", $time,
                     exp_n.last, out_mon.last);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_letters.size();
  end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none

module testbench;

  localparam int unsigned VW = rne_pkg::VALUE_W;
  localparam int unsigned CW = rne_pkg::COUNT_W;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   accepted_items = 0;
  bit   calm = 1'b0;

  rne_in_if  in_if ();
  rne_out_if out_if ();

  roman_numeral_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  rne_numeral_checker checker_u (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(input logic [VW-1:0] value,
                           input logic [CW-1:0] digit_count);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.value       <= value;
    in_if.digit_count <= digit_count;
    do @(posedge clk_i); while (!in_if.ready);
    accepted_items++;
  endtask

  // Output side: random stall bursts, one long hold-off once traffic is flowing.
  initial begin
    int idle_left;
    bit held;
    idle_left = 0;
    held      = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (!held && accepted_items >= 40) begin
          held      = 1'b1;
          idle_left = 250;
        end else if (idle_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
          idle_left = $urandom_range(1, 15);
        end
        if (idle_left > 0) begin
          out_if.ready <= 1'b0;
          idle_left--;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.value       <= '0;
    in_if.digit_count <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(14'd1, 3'd1);
    send_item(14'd4, 3'd1);
    send_item(14'd5, 3'd1);
    send_item(14'd8, 3'd1);
    send_item(14'd9, 3'd1);
    send_item(14'd0, 3'd1);
    send_item(14'd0, 3'd4);
    send_item(14'd40, 3'd2);
    send_item(14'd90, 3'd2);
    send_item(14'd400, 3'd3);
    send_item(14'd900, 3'd3);
    send_item(14'd2000, 3'd4);
    send_item(14'd3999, 3'd4);
    send_item(14'd3888, 3'd4);
    // thousands digit above three
    send_item(14'd4000, 3'd4);
    send_item(14'd9999, 3'd4);
    // value wider than the named positions
    send_item(14'd10, 3'd1);
    send_item(14'd1234, 3'd2);
    send_item(14'd16383, 3'd4);
    // count of zero, and counts past four
    send_item(14'd123, 3'd0);
    send_item(14'd16383, 3'd7);
    send_item(14'd5, 3'd5);
    send_item(14'd2768, 3'd6);
    send_item(14'd707, 3'd3);

    for (int i = 0; i < 146; i++) begin
      int            pick;
      logic [CW-1:0] cnt;
      logic [VW-1:0] val;
      calm = (i >= 120);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        cnt = CW'($urandom_range(1, 4));
        val = VW'($urandom_range(1, (cnt == 4) ? 3999 : (10 ** int'(cnt)) - 1));
      end else if (pick < 85) begin
        cnt = CW'($urandom_range(1, 4));
        val = VW'($urandom_range(0, 9999));
      end else begin
        cnt = CW'($urandom());
        val = VW'($urandom());
      end
      send_item(val, cnt);
    end
    in_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
